// ===== src/rfrp_pkg.sv =====
// ----------------------------------------------------------------------------
// RS-485 frame receive parser package
// Shared types, codes and constants of the frame receive parser.
// ----------------------------------------------------------------------------
package rfrp_pkg;

    localparam int unsigned SERIAL_BYTES = 12;

    localparam logic [7:0] PREAMBLE   = 8'hBE;
    localparam logic [7:0] FLAGS_MASK = 8'hF0;
    localparam logic [7:0] FLAGS_CODE = 8'h50;

    // Flag bit positions within the flags byte.
    localparam int unsigned FLAG_DIR   = 0;
    localparam int unsigned FLAG_BCAST = 1;
    localparam int unsigned FLAG_LONG  = 2;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_NODE_ID     = 2'd0;
    localparam t_cfg_index CFG_SERIAL_LOW  = 2'd1;
    localparam t_cfg_index CFG_SERIAL_HIGH = 2'd2;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_DATA      = 3'd1,
        EV_ACCEPT    = 3'd2,
        EV_IGNORED   = 3'd3,
        EV_CSUM_FAIL = 3'd4,
        EV_FRAMING   = 3'd5
    } t_event;

    typedef struct packed {
        logic [7:0]  node_id;
        logic [63:0] serial_low;
        logic [31:0] serial_high;
    } t_cfg;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] data;
        logic [7:0] byte_index;
        logic [7:0] length;
        logic       serial_form;
        logic       broadcast;
    } t_result;

endpackage

// ===== src/rfrp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the node id and the 12-byte serial number written over the config port.
// ----------------------------------------------------------------------------
module rfrp_cfg_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  rfrp_pkg::t_cfg_index  i_cfg_index,
    input  logic [63:0]           i_cfg_data,
    output rfrp_pkg::t_cfg        o_cfg
);
    import rfrp_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NODE_ID:     n_cfg.node_id     = i_cfg_data[7:0];
                CFG_SERIAL_LOW:  n_cfg.serial_low  = i_cfg_data;
                CFG_SERIAL_HIGH: n_cfg.serial_high = i_cfg_data[31:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/rfrp_parser.sv =====
// ----------------------------------------------------------------------------
// Frame parser core
// Packet state machine, checksum and address compare; one byte per step.
// ----------------------------------------------------------------------------
module rfrp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  rfrp_pkg::t_cfg    i_cfg,
    output rfrp_pkg::t_result o_result
);
    import rfrp_pkg::*;

    typedef enum logic [6:0] {
        PH_HUNT   = 7'b0000001,
        PH_FLAGS  = 7'b0000010,
        PH_ADDR   = 7'b0000100,
        PH_LEN    = 7'b0001000,
        PH_BODY   = 7'b0010000,
        PH_TRAIL0 = 7'b0100000,
        PH_TRAIL1 = 7'b1000000
    } t_phase;

    t_phase      r_phase,     n_phase;
    logic [15:0] r_sum,       n_sum;
    logic [7:0]  r_trail_low, n_trail_low;
    logic [7:0]  r_decl_len,  n_decl_len;
    logic [7:0]  r_pos,       n_pos;
    logic        r_ignore,    n_ignore;
    logic        r_bcast,     n_bcast;
    logic        r_long,      n_long;

    logic [15:0] w_sum_step;
    logic [7:0]  w_serial_byte;
    logic [8:0]  w_pos_inc;
    t_event      w_event;

    // Rotate left by one, then fold in the byte.
    assign w_sum_step = {r_sum[14:0], r_sum[15]} ^ {8'h00, i_byte};
    assign w_pos_inc  = {1'b0, r_pos} + 9'd1;

    always_comb begin
        w_serial_byte = 8'h00;
        if (r_pos < 8'(SERIAL_BYTES)) begin
            case (r_pos[3:0])
                4'd0:    w_serial_byte = i_cfg.serial_low[7:0];
                4'd1:    w_serial_byte = i_cfg.serial_low[15:8];
                4'd2:    w_serial_byte = i_cfg.serial_low[23:16];
                4'd3:    w_serial_byte = i_cfg.serial_low[31:24];
                4'd4:    w_serial_byte = i_cfg.serial_low[39:32];
                4'd5:    w_serial_byte = i_cfg.serial_low[47:40];
                4'd6:    w_serial_byte = i_cfg.serial_low[55:48];
                4'd7:    w_serial_byte = i_cfg.serial_low[63:56];
                4'd8:    w_serial_byte = i_cfg.serial_high[7:0];
                4'd9:    w_serial_byte = i_cfg.serial_high[15:8];
                4'd10:   w_serial_byte = i_cfg.serial_high[23:16];
                4'd11:   w_serial_byte = i_cfg.serial_high[31:24];
                default: w_serial_byte = 8'h00;
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_sum       = r_sum;
        n_trail_low = r_trail_low;
        n_decl_len  = r_decl_len;
        n_pos       = r_pos;
        n_ignore    = r_ignore;
        n_bcast     = r_bcast;
        n_long      = r_long;
        w_event     = EV_NONE;
        o_result    = '0;

        case (r_phase)
            PH_HUNT: begin
                if (i_byte == PREAMBLE) begin
                    n_sum   = {8'h00, i_byte};
                    n_phase = PH_FLAGS;
                end
            end
            PH_FLAGS: begin
                n_sum = w_sum_step;
                if ((i_byte & FLAGS_MASK) != FLAGS_CODE) begin
                    n_phase = PH_HUNT;
                    w_event = EV_FRAMING;
                end else begin
                    n_ignore = i_byte[FLAG_DIR];
                    n_bcast  = i_byte[FLAG_BCAST];
                    n_long   = i_byte[FLAG_LONG];
                    n_pos    = 8'h00;
                    n_phase  = i_byte[FLAG_BCAST] ? PH_LEN : PH_ADDR;
                end
            end
            PH_ADDR: begin
                n_sum = w_sum_step;
                if (r_long) begin
                    if (i_byte != w_serial_byte) begin
                        n_ignore = 1'b1;
                    end
                    n_pos = w_pos_inc[7:0];
                    if (w_pos_inc[7:0] >= 8'(SERIAL_BYTES)) begin
                        n_phase = PH_LEN;
                    end
                end else begin
                    if (i_byte != i_cfg.node_id) begin
                        n_ignore = 1'b1;
                    end
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_sum = w_sum_step;
                if (i_byte == 8'h00) begin
                    n_phase = PH_HUNT;
                    w_event = EV_FRAMING;
                end else begin
                    n_decl_len = i_byte;
                    n_pos      = 8'h00;
                    n_phase    = PH_BODY;
                end
            end
            PH_BODY: begin
                n_sum               = w_sum_step;
                w_event             = EV_DATA;
                o_result.data       = i_byte;
                o_result.byte_index = r_pos;
                if (w_pos_inc >= {1'b0, r_decl_len}) begin
                    n_phase = PH_TRAIL0;
                end
                if (r_pos != 8'hFF) begin
                    n_pos = w_pos_inc[7:0];
                end
            end
            PH_TRAIL0: begin
                n_trail_low = i_byte;
                n_phase     = PH_TRAIL1;
            end
            PH_TRAIL1: begin
                n_phase = PH_HUNT;
                if ({i_byte, r_trail_low} == r_sum) begin
                    w_event = r_ignore ? EV_IGNORED : EV_ACCEPT;
                end else begin
                    w_event = EV_CSUM_FAIL;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase

        o_result.event_res = w_event;
        // Packet attributes travel only with events that belong to a packet.
        if (w_event inside {[EV_DATA:EV_CSUM_FAIL]}) begin
            o_result.length      = r_decl_len;
            o_result.serial_form = r_long;
            o_result.broadcast   = r_bcast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_sum       <= '0;
            r_trail_low <= '0;
            r_decl_len  <= '0;
            r_pos       <= '0;
            r_ignore    <= 1'b0;
            r_bcast     <= 1'b0;
            r_long      <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_sum       <= n_sum;
            r_trail_low <= n_trail_low;
            r_decl_len  <= n_decl_len;
            r_pos       <= n_pos;
            r_ignore    <= n_ignore;
            r_bcast     <= n_bcast;
            r_long      <= n_long;
        end
    end

endmodule

// ===== src/rs485_frame_receive_parser.sv =====
// ----------------------------------------------------------------------------
// RS-485 frame receive parser
// Finds packets in a received byte stream, filters them by address, streams
// the payload and checks the 16-bit rotate-and-XOR trailer.
// ----------------------------------------------------------------------------
// Usage:
//   Received bytes enter on the rx channel (i_rx_valid / o_rx_ready) and each
//   one produces exactly one result on the result channel (o_res_valid /
//   i_res_ready): nothing, a payload byte, a packet verdict or a framing error.
//   Downstream must discard payload bytes of a packet whose verdict is not
//   "accepted".
//   The node id and serial number are written on the config channel, which is
//   always ready; write it only while no byte is in flight.
//   A byte accepted on the rx channel waits in the input register; its result
//   is then registered in the output register and offered from then on.
//   Throughput: one byte per cycle while the receiver does not stall, set
//   by the parser state update between the input and the result register.
//   When the receiver stalls, the result holds in the output register, one
//   further byte waits in the input register, and o_rx_ready then drops until
//   the result transfer completes.
//   Reset clears both pipeline stages, the parser returns to the preamble hunt
//   and all configuration registers read zero.
// ----------------------------------------------------------------------------
module rs485_frame_receive_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // received byte channel
    input  logic                 i_rx_valid,
    output logic                 o_rx_ready,
    input  logic [7:0]           i_rx_byte,
    // result channel
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic [2:0]           o_event_res,
    output logic [7:0]           o_data,
    output logic [7:0]           o_byte_index,
    output logic [7:0]           o_length,
    output logic                 o_serial_form,
    output logic                 o_broadcast,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  rfrp_pkg::t_cfg_index i_cfg_index,
    input  logic [63:0]          i_cfg_data
);
    import rfrp_pkg::*;

    // Input stage: one received byte waiting for the parser.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Output stage: the registered result of the last parsed byte.
    logic    r_out_valid;
    t_result r_out;

    logic    w_move;
    t_cfg    w_cfg;
    t_result w_result;

    // A byte is parsed when it sits in the input stage and the output stage is
    // free, or is being emptied by a transfer in this very cycle.
    assign w_move      = r_in_valid && (!r_out_valid || i_res_ready);
    assign o_rx_ready  = !r_in_valid || w_move;
    assign o_cfg_ready = 1'b1;

    rfrp_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // The parser advances its packet state only on the cycle its byte moves on.
    rfrp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_move),
        .i_byte   (r_in_byte),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && o_rx_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= w_result;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_event_res   = r_out.event_res;
    assign o_data        = r_out.data;
    assign o_byte_index  = r_out.byte_index;
    assign o_length      = r_out.length;
    assign o_serial_form = r_out.serial_form;
    assign o_broadcast   = r_out.broadcast;

    // A parsed byte always lands in the output stage.
    a_move_fills_output : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> r_out_valid
    ) else $error("parsed byte did not reach the output stage");

    // Input back-pressure only arises when both stages are full and stalled.
    a_ready_low_only_when_full : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_rx_ready |-> (r_in_valid && r_out_valid && !i_res_ready)
    ) else $error("rx channel stalled while a stage was free");

    // Payload data and index are zero unless the result is a payload byte.
    a_data_only_on_payload : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.event_res != EV_DATA))
            |-> (r_out.data == 8'h00 && r_out.byte_index == 8'h00)
    ) else $error("payload fields set on a non-payload result");

    // Packet attributes are zero on results that do not belong to a packet.
    a_attr_only_in_packet : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.event_res == EV_NONE || r_out.event_res == EV_FRAMING))
            |-> (r_out.length == 8'h00 && !r_out.serial_form && !r_out.broadcast)
    ) else $error("packet attributes set outside a packet");

    // A payload byte always belongs to a packet with a non-zero length.
    a_payload_has_length : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res == EV_DATA)
            |-> (r_out.length != 8'h00 && r_out.byte_index < r_out.length)
    ) else $error("payload byte outside the declared length");

endmodule

// ===== verif/rs485_frame_receive_parser_tb.sv =====
// ----------------------------------------------------------------------------
// RS-485 frame receive parser testbench
// Drives received bytes into the parser, predicts one event per byte in a
// scoreboard and compares every result transfer field by field. The run
// covers several address settings and several patterns of sender and
// receiver idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rs485_frame_receive_parser_tb;

    import rfrp_pkg::*;

    localparam int          CLK_HALF    = 10;
    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int unsigned PHASE_BYTES = 300;
    localparam int          PHASES      = 4;
    localparam int          TAIL_CYCLES = 8;

    // Flag bits of the flags byte, as masks.
    localparam logic [7:0] F_DIR   = 8'(1 << FLAG_DIR);
    localparam logic [7:0] F_BCAST = 8'(1 << FLAG_BCAST);
    localparam logic [7:0] F_LONG  = 8'(1 << FLAG_LONG);

    // Parser position within a frame, as the scoreboard tracks it.
    typedef enum logic [2:0] {
        ST_HUNT,
        ST_FLAGS,
        ST_ADDR,
        ST_LEN,
        ST_BODY,
        ST_TRAIL_LO,
        ST_TRAIL_HI
    } t_rx_phase;

    // ------------------------------------------------------------------------
    // Scoreboard: a shadow of the parser state and its address registers.
    // Every byte that the parser takes in is run through the shadow, and the
    // event it yields waits in a queue for the matching result transfer.
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        logic [7:0]  node_id;
        logic [63:0] serial_lo;
        logic [31:0] serial_hi;

        t_rx_phase   phase;
        logic [15:0] sum;
        logic [7:0]  trail_lo;
        logic [7:0]  len;
        logic [7:0]  pos;
        logic        ignore;
        logic        bcast;
        logic        long_addr;

        t_result     expected_events[$];
        int unsigned fail_count;

        function new();
            node_id    = '0;
            serial_lo  = '0;
            serial_hi  = '0;
            phase      = ST_HUNT;
            sum        = '0;
            trail_lo   = '0;
            len        = '0;
            pos        = '0;
            ignore     = 1'b0;
            bcast      = 1'b0;
            long_addr  = 1'b0;
            fail_count = 0;
        endfunction

        // One step of the checksum: rotate left by one, then fold in the byte.
        static function logic [15:0] fold_byte(logic [15:0] s, logic [7:0] b);
            return {s[14:0], s[15]} ^ {8'h00, b};
        endfunction

        function logic [7:0] serial_byte(int k);
            if (k < 8)
                return serial_lo[8 * k +: 8];
            return serial_hi[8 * (k - 8) +: 8];
        endfunction

        function void write_reg(t_cfg_index idx, logic [63:0] value);
            case (idx)
                CFG_NODE_ID:     node_id   = value[7:0];
                CFG_SERIAL_LOW:  serial_lo = value;
                CFG_SERIAL_HIGH: serial_hi = value[31:0];
                default: ;
            endcase
        endfunction

        // Advances the shadow parser by one byte and queues the event it gives.
        function void note_rx_byte(logic [7:0] b);
            t_result ev;
            ev = '0;
            ev.event_res = EV_NONE;
            case (phase)
                ST_HUNT: begin
                    if (b == PREAMBLE) begin
                        sum   = fold_byte(16'h0000, b);
                        phase = ST_FLAGS;
                    end
                end
                ST_FLAGS: begin
                    sum = fold_byte(sum, b);
                    if ((b & FLAGS_MASK) != FLAGS_CODE) begin
                        phase        = ST_HUNT;
                        ev.event_res = EV_FRAMING;
                    end else begin
                        ignore    = b[FLAG_DIR];
                        bcast     = b[FLAG_BCAST];
                        long_addr = b[FLAG_LONG];
                        pos       = '0;
                        phase     = bcast ? ST_LEN : ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    sum = fold_byte(sum, b);
                    if (long_addr) begin
                        // The serial number is matched one byte at a time.
                        if (b != serial_byte(pos))
                            ignore = 1'b1;
                        pos = pos + 8'd1;
                        if (pos >= SERIAL_BYTES)
                            phase = ST_LEN;
                    end else begin
                        if (b != node_id)
                            ignore = 1'b1;
                        phase = ST_LEN;
                    end
                end
                ST_LEN: begin
                    sum = fold_byte(sum, b);
                    if (b == 8'h00) begin
                        phase        = ST_HUNT;
                        ev.event_res = EV_FRAMING;
                    end else begin
                        len   = b;
                        pos   = '0;
                        phase = ST_BODY;
                    end
                end
                ST_BODY: begin
                    sum           = fold_byte(sum, b);
                    ev.event_res  = EV_DATA;
                    ev.data       = b;
                    ev.byte_index = pos;
                    if ({1'b0, pos} + 9'd1 >= {1'b0, len})
                        phase = ST_TRAIL_LO;
                    if (pos != 8'hFF)
                        pos = pos + 8'd1;
                end
                ST_TRAIL_LO: begin
                    trail_lo = b;
                    phase    = ST_TRAIL_HI;
                end
                ST_TRAIL_HI: begin
                    phase = ST_HUNT;
                    if ({b, trail_lo} == sum)
                        ev.event_res = ignore ? EV_IGNORED : EV_ACCEPT;
                    else
                        ev.event_res = EV_CSUM_FAIL;
                end
                default: phase = ST_HUNT;
            endcase
            // Packet attributes ride along with payload bytes and verdicts only.
            if (ev.event_res >= EV_DATA && ev.event_res <= EV_CSUM_FAIL) begin
                ev.length      = len;
                ev.serial_form = long_addr;
                ev.broadcast   = bcast;
            end
            expected_events.push_back(ev);
        endfunction

        local function bit field_ok(string name, int unsigned want, int unsigned got);
            if (want == got)
                return 1'b1;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            return 1'b0;
        endfunction

        function void check_event(t_result got);
            t_result want;
            bit      ok;
            if (expected_events.size() == 0) begin
                $display("%0t: result transfer with no byte outstanding, event %0d",
                         $time, got.event_res);
                fail_count++;
                return;
            end
            want = expected_events.pop_front();
            ok = field_ok("event_res", want.event_res, got.event_res);
            ok = field_ok("data", want.data, got.data) & ok;
            ok = field_ok("byte_index", want.byte_index, got.byte_index) & ok;
            ok = field_ok("length", want.length, got.length) & ok;
            ok = field_ok("serial_form", want.serial_form, got.serial_form) & ok;
            ok = field_ok("broadcast", want.broadcast, got.broadcast) & ok;
            if (!ok)
                fail_count++;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the unit under test.
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_rx_valid;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte;
    logic        o_res_valid;
    logic        i_res_ready;
    logic [2:0]  o_event_res;
    logic [7:0]  o_data;
    logic [7:0]  o_byte_index;
    logic [7:0]  o_length;
    logic        o_serial_form;
    logic        o_broadcast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_index  i_cfg_index;
    logic [63:0] i_cfg_data;

    rs485_frame_receive_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .o_rx_ready    (o_rx_ready),
        .i_rx_byte     (i_rx_byte),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_event_res   (o_event_res),
        .o_data        (o_data),
        .o_byte_index  (o_byte_index),
        .o_length      (o_length),
        .o_serial_form (o_serial_form),
        .o_broadcast   (o_broadcast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    frame_scoreboard sb;

    // Per-phase idling, in percent of cycles.
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;

    int unsigned cycles;
    int unsigned rx_count;
    logic [7:0]  frame_q[$];

    always #CLK_HALF i_clk = ~i_clk;

    // The cycle counter guards against a hang anywhere in the run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL rs485_frame_receive_parser");
            $finish;
        end
    end

    // The receiver stalls at random; the draw is made afresh at every falling
    // edge so that stalls land on every stage of the parser's work.
    always @(negedge i_clk) begin
        i_res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every result transfer is checked at the rising edge where it happens.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready)
            sb.check_event(t_result'({t_event'(o_event_res), o_data, o_byte_index,
                                      o_length, o_serial_form, o_broadcast}));
    end

    // ------------------------------------------------------------------------
    // Driving tasks. Each one is entered and left at a falling edge, so that
    // i_rx_valid gets a single assignment in any one time step.
    // ------------------------------------------------------------------------

    // Offers one byte, after a random gap, and holds it until the transfer.
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct) begin
            i_rx_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        sb.note_rx_byte(b);
        rx_count++;
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        while (frame_q.size() != 0)
            push_byte(frame_q.pop_front());
    endtask

    // Holds the sender off until every outstanding byte has produced its
    // result, then lets the pipeline settle.
    task automatic wait_drained();
        i_rx_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // The configuration channel is left high between back-to-back writes;
    // program_regs lowers it once all three registers are written.
    task automatic cfg_write(input t_cfg_index idx, input logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, value);
        @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [7:0] node, input logic [63:0] ser_lo,
                                input logic [31:0] ser_hi);
        cfg_write(CFG_NODE_ID, {56'h0, node});
        cfg_write(CFG_SERIAL_LOW, ser_lo);
        cfg_write(CFG_SERIAL_HIGH, {32'h0, ser_hi});
        i_cfg_valid <= 1'b0;
    endtask

    // Builds a frame in frame_q from the registers last written. addr_miss
    // picks an address byte to spoil (negative for none) and sum_flip is
    // XORed into the trailer. Bad flags or a zero length end the frame early,
    // as the parser drops back to the hunt at that point.
    function automatic void build_frame(input logic [7:0] flags, input logic [7:0] len,
                                        input int addr_miss, input logic [15:0] sum_flip);
        logic [15:0] s;
        logic [7:0]  a;
        int          n_addr;
        frame_q.push_back(PREAMBLE);
        frame_q.push_back(flags);
        if ((flags & FLAGS_MASK) != FLAGS_CODE)
            return;
        n_addr = flags[FLAG_BCAST] ? 0 : (flags[FLAG_LONG] ? SERIAL_BYTES : 1);
        for (int k = 0; k < n_addr; k++) begin
            a = flags[FLAG_LONG] ? sb.serial_byte(k) : sb.node_id;
            if (k == addr_miss)
                a ^= 8'($urandom_range(1, 255));
            frame_q.push_back(a);
        end
        frame_q.push_back(len);
        if (len == 8'h00)
            return;
        for (int k = 0; k < len; k++)
            frame_q.push_back(8'($urandom));
        s = '0;
        foreach (frame_q[k])
            s = frame_scoreboard::fold_byte(s, frame_q[k]);
        s ^= sum_flip;
        frame_q.push_back(s[7:0]);
        frame_q.push_back(s[15:8]);
    endfunction

    // Mostly well-formed frames with random flags, addresses and payload; the
    // rest is line noise, bad flags, spoilt addresses, bad trailers and
    // frames cut short.
    task automatic send_random_frame();
        int unsigned pick;
        logic [7:0]  flags;
        logic [7:0]  len;
        int          miss;
        logic [15:0] flip;
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 4))
                push_byte(($urandom_range(3) == 0) ? PREAMBLE : 8'($urandom));
            return;
        end
        if (pick < 12) begin
            do flags = 8'($urandom); while ((flags & FLAGS_MASK) == FLAGS_CODE);
        end else begin
            flags = FLAGS_CODE | 8'($urandom_range(0, 15));
        end
        pick = $urandom_range(199);
        if (pick < 6)
            len = 8'h00;
        else if (pick < 20)
            len = 8'($urandom_range(9, 40));
        else
            len = 8'($urandom_range(1, 8));
        if ($urandom_range(99) < 15)
            miss = $urandom_range(0, flags[FLAG_LONG] ? SERIAL_BYTES - 1 : 0);
        else
            miss = -1;
        flip = ($urandom_range(99) < 12) ? 16'($urandom_range(1, 65535)) : 16'h0000;
        build_frame(flags, len, miss, flip);
        if ($urandom_range(99) < 5)
            repeat ($urandom_range(1, frame_q.size() - 1))
                void'(frame_q.pop_back());
        send_frame();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        sb             = new();
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_rx_valid     = 1'b0;
        i_rx_byte      = 8'h00;
        i_res_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_NODE_ID;
        i_cfg_data     = '0;
        cycles         = 0;
        rx_count       = 0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int p = 0; p < PHASES; p++) begin
            // Idling: none, sender only, receiver only, then both together.
            case (p)
                0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_gap_pct = 52; recv_stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  recv_stall_pct = 52; end
                default: begin send_gap_pct = 34; recv_stall_pct = 34; end
            endcase

            // The parser is idle here: after reset, or after a full drain.
            case (p)
                0:       program_regs(8'h00, 64'h0, 32'h0);
                1:       program_regs(8'hFF, '1, '1);
                default: program_regs(8'($urandom), {$urandom, $urandom}, $urandom);
            endcase

            if (p == 0) begin
                // Noise while hunting, then bad flags and a zero length, both
                // of which are framing errors.
                push_byte(8'h00);
                push_byte(8'hFF);
                build_frame(8'hFF, 8'd1, -1, 16'h0000);
                send_frame();
                build_frame(FLAGS_CODE | F_BCAST, 8'd0, -1, 16'h0000);
                send_frame();
                // A clean broadcast is accepted.
                build_frame(FLAGS_CODE | F_BCAST, 8'd1, -1, 16'h0000);
                send_frame();
                // A wrong node id with a bad trailer still gives checksum fail.
                build_frame(FLAGS_CODE, 8'd1, 0, 16'h0001);
                send_frame();
                // The direction bit marks an otherwise good packet as ignored.
                build_frame(FLAGS_CODE | F_BCAST | F_DIR, 8'd1, -1, 16'h0000);
                send_frame();
            end

            if (p == 2) begin
                // One long-address packet of the largest length.
                build_frame(FLAGS_CODE | F_LONG, 8'hFF, -1, 16'h0000);
                send_frame();
            end

            while (rx_count < (p + 1) * PHASE_BYTES) begin
                send_random_frame();
                if ($urandom_range(39) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("PASS rs485_frame_receive_parser");
        else
            $display("FAIL rs485_frame_receive_parser");
        $finish;
    end

endmodule
